/* rtl/pts_pkg.sv */
// pts_pkg: shared types, constants and operation codes of the periodic task scheduler
// no dependencies

package pts_pkg;

  localparam int SlotCountDef = 8;
  localparam int TaskIdsDef   = 4;
  localparam int MaxResults   = 4;
  localparam logic [31:0] MinInterval = 32'd1000;
  localparam logic [31:0] MaxInterval = 32'h7fff_ffff;

  typedef enum logic [2:0] {
    KIND_TICK     = 3'd0,
    KIND_REGISTER = 3'd1,
    KIND_CANCEL   = 3'd2,
    KIND_SET_EN   = 3'd3,
    KIND_UPDATE   = 3'd4,
    KIND_RESCHED  = 3'd5,
    KIND_TRIGGER  = 3'd6,
    KIND_QUERY    = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_FIRE,
    ST_WAIT,
    ST_EMIT
  } state_t;

  // one slot's stored contents
  typedef struct packed {
    logic        used;
    logic [1:0]  task_id;
    logic        enabled;
    logic [30:0] period;
    logic [31:0] since;
    logic [63:0] seq;
  } slot_t;

  // command broadcast from the controller to every cell
  typedef struct packed {
    logic        apply;     // apply op to addressed cell
    logic [2:0]  kind;
    logic [1:0]  task_id;
    logic [31:0] now_ms;
    logic [30:0] interval;
    logic        enable;
    logic [63:0] new_seq;
    logic        fire_seq;  // tick fire of the slot holding fire_sel
    logic [63:0] fire_sel;
  } cell_cmd_t;

  function automatic logic interval_ok(input logic [31:0] v);
    return (v >= MinInterval) && (v <= MaxInterval);
  endfunction

endpackage

/* rtl/pts_cell.sv */
// pts_cell: one slot of the task table plus its stage of the scan chain
// depends on pts_pkg

module pts_cell
  import pts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cell_cmd_t   cmd,
  input  logic        sel,        // this cell is the addressed or free slot
  input  logic [63:0] prev_seq,   // tick: least sequence above this is picked next
  // chain from upstream neighbor
  input  logic        chn_any_i,
  input  logic [30:0] chn_best_i,
  input  logic        chn_pick_i,
  input  logic [63:0] chn_seq_i,
  input  logic [1:0]  chn_task_i,
  input  logic        chn_due_i,
  output logic        chn_any_o,
  output logic [30:0] chn_best_o,
  output logic        chn_pick_o,
  output logic [63:0] chn_seq_o,
  output logic [1:0]  chn_task_o,
  output logic        chn_due_o,
  output slot_t       slot_o
);

  slot_t slot_r, slot_nxt;
  logic [31:0] elapsed;
  logic [30:0] wait_ms;
  logic        due;
  logic        cand;

  assign slot_o  = slot_r;
  assign elapsed = cmd.now_ms - slot_r.since;
  assign due     = elapsed >= {1'b0, slot_r.period};
  assign wait_ms = due ? 31'd0 : (slot_r.period - elapsed[30:0]);
  assign cand    = slot_r.used && (slot_r.seq > prev_seq);

  // nearest wait and next-in-sequence search pass down the row
  always_comb begin
    chn_any_o  = chn_any_i;
    chn_best_o = chn_best_i;
    if (slot_r.used && slot_r.enabled) begin
      chn_any_o = 1'b1;
      if (!chn_any_i || wait_ms < chn_best_i) chn_best_o = wait_ms;
    end
    chn_pick_o = chn_pick_i;
    chn_seq_o  = chn_seq_i;
    chn_task_o = chn_task_i;
    chn_due_o  = chn_due_i;
    if (cand && (!chn_pick_i || slot_r.seq < chn_seq_i)) begin
      chn_pick_o = 1'b1;
      chn_seq_o  = slot_r.seq;
      chn_task_o = slot_r.task_id;
      chn_due_o  = slot_r.enabled && due;
    end
  end

  always_comb begin
    slot_nxt = slot_r;
    if (cmd.fire_seq && slot_r.used && slot_r.seq == cmd.fire_sel && slot_r.enabled)
      slot_nxt.since = cmd.now_ms;
    if (cmd.apply && sel) begin
      unique case (kind_t'(cmd.kind))
        KIND_REGISTER: begin
          slot_nxt.used    = 1'b1;
          slot_nxt.task_id = cmd.task_id;
          slot_nxt.enabled = cmd.enable;
          slot_nxt.period  = cmd.interval;
          slot_nxt.since   = cmd.now_ms;
          slot_nxt.seq     = cmd.new_seq;
        end
        KIND_CANCEL: slot_nxt = '0;
        KIND_SET_EN: begin
          slot_nxt.enabled = cmd.enable;
          if (cmd.enable && !slot_r.enabled) slot_nxt.since = cmd.now_ms;
        end
        KIND_UPDATE: begin
          slot_nxt.period = cmd.interval;
          slot_nxt.since  = cmd.now_ms;
        end
        KIND_RESCHED: slot_nxt.since = cmd.now_ms;
        KIND_TRIGGER: if (slot_r.enabled) slot_nxt.since = cmd.now_ms;
        KIND_TICK, KIND_QUERY: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) slot_r <= '0;
    else        slot_r <= slot_nxt;
  end

endmodule

/* rtl/pts_ctrl.sv */
// pts_ctrl: sequencer for one command: apply, tick fire walk, result emission
// depends on pts_pkg

module pts_ctrl
  import pts_pkg::*;
#(
  parameter int SLOT_COUNT = SlotCountDef,
  parameter int TASK_IDS   = TaskIdsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [1:0]  in_task_id,
  input  logic [31:0] in_now_ms,
  input  logic [31:0] in_interval_ms,
  input  logic        in_enable_flag,
  input  logic        in_run_at_once,
  input  slot_t       slots [SLOT_COUNT],
  // chain tail
  input  logic        tail_any,
  input  logic [30:0] tail_best,
  input  logic        tail_pick,
  input  logic [63:0] tail_seq,
  input  logic [1:0]  tail_task,
  input  logic        tail_due,
  output cell_cmd_t   cmd,
  output logic [SLOT_COUNT-1:0] sel,
  output logic [63:0] prev_seq,
  output logic        out_valid,
  output logic        out_ok,
  output logic        out_fired,
  output logic [1:0]  out_fired_task,
  output logic        out_last,
  output logic        out_task_enabled,
  output logic [30:0] out_task_interval,
  output logic        out_any_waiting,
  output logic [30:0] out_nearest_wait
);

  localparam int CW = $clog2(MaxResults + 1);

  state_t state_r, state_nxt;
  logic [2:0]  kind_r;
  logic [1:0]  tid_r;
  logic [31:0] now_r;
  logic [31:0] ivl_r;
  logic        en_r, once_r;
  logic [63:0] seq_cnt_r, seq_cnt_nxt;
  logic [63:0] prev_r, prev_nxt;
  logic        first_r, first_nxt;
  logic        ok_r, ok_nxt;
  logic        fired_r, fired_nxt;
  logic [1:0]  ftask_r [MaxResults];
  logic [CW-1:0] nres_r, nres_nxt, emit_r, emit_nxt;

  logic [SLOT_COUNT-1:0] hit, freev, free_first;
  logic found, any_free, do_apply, reg_ok, tid_valid;
  logic [SLOT_COUNT-1:0] hit_first;

  assign tid_valid = {30'd0, tid_r} < TASK_IDS;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      hit[i]   = slots[i].used && slots[i].task_id == tid_r;
      freev[i] = !slots[i].used;
    end
    hit_first  = hit & (~hit + 1'b1);
    free_first = freev & (~freev + 1'b1);
  end
  assign found    = |hit;
  assign any_free = |freev;
  assign reg_ok   = tid_valid && interval_ok(ivl_r) && !found && (seq_cnt_r != '1) && any_free;

  always_comb begin
    do_apply = 1'b0;
    ok_nxt   = ok_r;
    fired_nxt = fired_r;
    if (state_r == ST_APPLY) begin
      unique case (kind_t'(kind_r))
        KIND_TICK: begin ok_nxt = 1'b1; fired_nxt = 1'b0; end
        KIND_REGISTER: begin
          do_apply  = reg_ok;
          ok_nxt    = reg_ok;
          fired_nxt = reg_ok && en_r && once_r;
        end
        KIND_UPDATE: begin
          do_apply  = found && interval_ok(ivl_r);
          ok_nxt    = do_apply;
          fired_nxt = 1'b0;
        end
        KIND_TRIGGER: begin do_apply = found; ok_nxt = found; fired_nxt = found; end
        default: begin do_apply = found; ok_nxt = found; fired_nxt = 1'b0; end
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.apply    = do_apply;
    cmd.kind     = kind_r;
    cmd.task_id  = tid_r;
    cmd.now_ms   = now_r;
    cmd.interval = ivl_r[30:0];
    cmd.enable   = en_r;
    cmd.new_seq  = seq_cnt_r + 64'd1;
    cmd.fire_seq = (state_r == ST_FIRE) && tail_pick && tail_due && ({1'b0, nres_r} < MaxResults);
    cmd.fire_sel = tail_seq;
    sel          = (kind_r == KIND_REGISTER) ? free_first : hit_first;
  end
  assign prev_seq = first_r ? 64'd0 : prev_r;

  always_comb begin
    unique case (state_r)
      ST_IDLE:  state_nxt = start ? ST_APPLY : ST_IDLE;
      ST_APPLY: state_nxt = (kind_r == KIND_TICK) ? ST_FIRE : ST_WAIT;
      ST_FIRE:  state_nxt = tail_pick ? ST_FIRE : ST_WAIT;
      ST_WAIT:  state_nxt = ST_EMIT;
      ST_EMIT:  state_nxt = (emit_r + 1'b1 >= nres_r) ? ST_IDLE : ST_EMIT;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    seq_cnt_nxt = seq_cnt_r;
    prev_nxt    = prev_r;
    first_nxt   = first_r;
    nres_nxt    = nres_r;
    emit_nxt    = emit_r;
    unique case (state_r)
      ST_IDLE: begin first_nxt = 1'b1; nres_nxt = '0; emit_nxt = '0; end
      ST_APPLY: begin
        if (kind_r == KIND_REGISTER && reg_ok) seq_cnt_nxt = seq_cnt_r + 64'd1;
        if (kind_r != KIND_TICK) nres_nxt = CW'(1);
      end
      ST_FIRE: begin
        if (tail_pick) begin
          first_nxt = 1'b0;
          prev_nxt  = tail_seq;
          if (cmd.fire_seq) nres_nxt = nres_r + 1'b1;
        end else if (nres_r == '0) begin
          nres_nxt = CW'(1);
        end
      end
      ST_WAIT: ;
      ST_EMIT: emit_nxt = emit_r + 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      seq_cnt_r <= '0;
      first_r   <= 1'b1;
      nres_r    <= '0;
      emit_r    <= '0;
      prev_r    <= '0;
      ok_r      <= 1'b0;
      fired_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      seq_cnt_r <= seq_cnt_nxt;
      first_r   <= first_nxt;
      nres_r    <= nres_nxt;
      emit_r    <= emit_nxt;
      prev_r    <= prev_nxt;
      ok_r      <= ok_nxt;
      fired_r   <= (state_r == ST_FIRE) ? (fired_r | cmd.fire_seq) : fired_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      kind_r <= in_kind;
      tid_r  <= in_task_id;
      now_r  <= in_now_ms;
      ivl_r  <= in_interval_ms;
      en_r   <= in_enable_flag;
      once_r <= in_run_at_once;
    end
    if (state_r == ST_APPLY) ftask_r[0] <= tid_r;
    if (cmd.fire_seq) ftask_r[nres_r[$clog2(MaxResults)-1:0]] <= tail_task;
  end

  assign busy = state_r != ST_IDLE;

  always_comb begin
    out_valid         = state_r == ST_EMIT;
    out_ok            = ok_r;
    out_fired         = (kind_r == KIND_TICK) ? fired_r : fired_r;
    out_fired_task    = '0;
    if (kind_r == KIND_TICK) begin
      out_fired = fired_r && (emit_r < nres_r);
      out_fired_task = fired_r ? ftask_r[emit_r[$clog2(MaxResults)-1:0]] : 2'd0;
    end else if (fired_r) begin
      out_fired_task = ftask_r[0];
    end
    out_last          = (emit_r + 1'b1) >= nres_r;
    out_task_enabled  = 1'b0;
    out_task_interval = '0;
    for (int i = 0; i < SLOT_COUNT; i++)
      if (hit_first[i]) begin
        out_task_enabled  = slots[i].enabled;
        out_task_interval = slots[i].period;
      end
    out_any_waiting  = tail_any;
    out_nearest_wait = tail_any ? tail_best : 31'd0;
  end

endmodule

/* rtl/periodic_task_scheduler_top.sv */
// periodic_task_scheduler_top: task slot row and command sequencer
// depends on pts_pkg, pts_cell, pts_ctrl

// A command is taken when start is high and busy low. A non-tick command gives
// one result. A tick walks the slot row once per cycle in registration order,
// one step per occupied slot plus one, then delivers one result per firing (at
// most four, at least one). Results appear with out_valid for one cycle each and
// cannot be stalled.

module periodic_task_scheduler_top
  import pts_pkg::*;
#(
  parameter int SLOT_COUNT = SlotCountDef,
  parameter int TASK_IDS   = TaskIdsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [1:0]  in_task_id,
  input  logic [31:0] in_now_ms,
  input  logic [31:0] in_interval_ms,
  input  logic        in_enable_flag,
  input  logic        in_run_at_once,
  output logic        out_valid,
  output logic        out_ok,
  output logic        out_fired,
  output logic [1:0]  out_fired_task,
  output logic        out_last,
  output logic        out_task_enabled,
  output logic [30:0] out_task_interval,
  output logic        out_any_waiting,
  output logic [30:0] out_nearest_wait
);

  cell_cmd_t cmd;
  logic [SLOT_COUNT-1:0] sel;
  logic [63:0] prev_seq;
  slot_t slots [SLOT_COUNT];
  logic        c_any  [SLOT_COUNT+1];
  logic [30:0] c_best [SLOT_COUNT+1];
  logic        c_pick [SLOT_COUNT+1];
  logic [63:0] c_seq  [SLOT_COUNT+1];
  logic [1:0]  c_task [SLOT_COUNT+1];
  logic        c_due  [SLOT_COUNT+1];

  assign c_any[0]  = 1'b0;
  assign c_best[0] = '0;
  assign c_pick[0] = 1'b0;
  assign c_seq[0]  = '0;
  assign c_task[0] = '0;
  assign c_due[0]  = 1'b0;

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    pts_cell u_cell (
      .clk, .rst_n, .cmd, .sel(sel[g]), .prev_seq,
      .chn_any_i(c_any[g]), .chn_best_i(c_best[g]), .chn_pick_i(c_pick[g]),
      .chn_seq_i(c_seq[g]), .chn_task_i(c_task[g]), .chn_due_i(c_due[g]),
      .chn_any_o(c_any[g+1]), .chn_best_o(c_best[g+1]), .chn_pick_o(c_pick[g+1]),
      .chn_seq_o(c_seq[g+1]), .chn_task_o(c_task[g+1]), .chn_due_o(c_due[g+1]),
      .slot_o(slots[g])
    );
  end

  pts_ctrl #(.SLOT_COUNT(SLOT_COUNT), .TASK_IDS(TASK_IDS)) u_ctrl (
    .clk, .rst_n, .start, .busy,
    .in_kind, .in_task_id, .in_now_ms, .in_interval_ms, .in_enable_flag, .in_run_at_once,
    .slots,
    .tail_any(c_any[SLOT_COUNT]), .tail_best(c_best[SLOT_COUNT]),
    .tail_pick(c_pick[SLOT_COUNT]), .tail_seq(c_seq[SLOT_COUNT]),
    .tail_task(c_task[SLOT_COUNT]), .tail_due(c_due[SLOT_COUNT]),
    .cmd, .sel, .prev_seq,
    .out_valid, .out_ok, .out_fired, .out_fired_task, .out_last,
    .out_task_enabled, .out_task_interval, .out_any_waiting, .out_nearest_wait
  );

endmodule

/* rtl/pts_checker.sv */
// pts_checker: port-level assertions for the scheduler, bound to the top level
// depends on pts_pkg

module pts_checker
  import pts_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic        out_fired,
  input logic [1:0]  out_fired_task,
  input logic        out_last,
  input logic        out_any_waiting,
  input logic [30:0] out_nearest_wait
);

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised");
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid) else $error("beat after last");
  a_no_beat_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("beat while idle");
  a_wait_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_any_waiting |-> out_nearest_wait == '0) else $error("wait");
  a_ftask_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fired |-> out_fired_task == '0) else $error("fired task");

endmodule

bind periodic_task_scheduler_top pts_checker u_pts_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_fired, .out_fired_task,
  .out_last, .out_any_waiting, .out_nearest_wait
);
